// ===== rtl/ins_pkg.sv =====
// ----------------------------------------------------------------------------
// ins_pkg
// Shared types and constants for the insertion sorter and its cells.
// ----------------------------------------------------------------------------
package ins_pkg;

   localparam int unsigned DEPTH_DEFAULT = 16;
   localparam int unsigned VALUE_W       = 32;

   // input word
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } req_word_type;

   // result word
   typedef struct packed {
      logic signed [VALUE_W-1:0] value_res;
      logic                      last_res;
      logic                      overflow;
   } rsp_word_type;

   // per-cell control from the top level
   typedef struct packed {
      logic insert;    // insert the broadcast value this cycle
      logic drain;     // shift the chain one place towards cell 0
      logic occupied;  // cell index below the fill count
      logic at_fill;   // cell index equals the fill count
   } cell_ctrl_type;

endpackage

// ===== rtl/ins_cell.sv =====
// ----------------------------------------------------------------------------
// ins_cell
// One entry of the sorted chain: compares its value with the broadcast
// value, then keeps, takes the new value, or takes a neighbour's value.
// ----------------------------------------------------------------------------
module ins_cell (
   input  logic                                clock,
   input  ins_pkg::cell_ctrl_type              ctrl,
   input  logic signed [ins_pkg::VALUE_W-1:0]  new_value,
   input  logic signed [ins_pkg::VALUE_W-1:0]  left_value,
   input  logic                                left_gt,
   input  logic signed [ins_pkg::VALUE_W-1:0]  right_value,
   output logic signed [ins_pkg::VALUE_W-1:0]  value,
   output logic                                gt
);

   logic signed [ins_pkg::VALUE_W-1:0] value_ff;
   logic signed [ins_pkg::VALUE_W-1:0] value_in;

   // stored entry strictly greater than the new value (equal values stay put)
   assign gt = ctrl.occupied && (value_ff > new_value);

   // next entry value
   always_comb begin
      value_in = value_ff;
      if (ctrl.drain) begin
         value_in = right_value;
      end else if (ctrl.insert) begin
         if (left_gt) begin
            value_in = left_value;
         end else if (gt || ctrl.at_fill) begin
            value_in = new_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ===== rtl/insertion_sorter.sv =====
// ----------------------------------------------------------------------------
// insertion_sorter
// Stable ascending insertion sort over a chain of DEPTH cells.
// ----------------------------------------------------------------------------
// Throughput: one word taken per cycle while a run is being loaded, and
// inserted while not full. After the word marked last, the stored words
// drain one word per cycle from cell 0 while the output is not stalled;
// no input is taken then. The first result passes the state register and
// then the output register. Reset: synchronous; clears fill count, overflow
// flag and output valid. Cell contents are not reset and count as empty.
module insertion_sorter #(
   parameter int unsigned DEPTH = ins_pkg::DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ins_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ins_pkg::rsp_word_type rsp_word
);

   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   localparam logic ST_LOAD  = 1'b0;
   localparam logic ST_DRAIN = 1'b1;

   logic                 state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 ovf_ff, ovf_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   ins_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic req_take;
   logic full;
   logic do_insert;
   logic do_drain;

   logic signed [ins_pkg::VALUE_W-1:0] cell_value [DEPTH];
   logic                               cell_gt    [DEPTH];

   assign req_ready = (state_ff == ST_LOAD);
   assign req_take  = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign do_insert = req_take && !full;
   assign do_drain  = (state_ff == ST_DRAIN) && (!rsp_valid_ff || rsp_ready);

   // cell chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      ins_pkg::cell_ctrl_type             ctrl;
      logic signed [ins_pkg::VALUE_W-1:0] left_v;
      logic                               left_g;
      logic signed [ins_pkg::VALUE_W-1:0] right_v;

      assign ctrl.insert   = do_insert;
      assign ctrl.drain    = do_drain;
      assign ctrl.occupied = (CNT_W'(i) < count_ff);
      assign ctrl.at_fill  = (CNT_W'(i) == count_ff);

      if (i == 0) begin : g_first
         assign left_v = cell_value[0];
         assign left_g = 1'b0;
      end else begin : g_mid
         assign left_v = cell_value[i-1];
         assign left_g = cell_gt[i-1];
      end

      if (i == DEPTH - 1) begin : g_end
         assign right_v = cell_value[i];
      end else begin : g_inner
         assign right_v = cell_value[i+1];
      end

      ins_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .new_value   (req_word.value),
         .left_value  (left_v),
         .left_gt     (left_g),
         .right_value (right_v),
         .value       (cell_value[i]),
         .gt          (cell_gt[i])
      );
   end

   // run control and output register
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_word.last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (do_drain) begin
               rsp_valid_in          = 1'b1;
               rsp_word_in.value_res = cell_value[0];
               rsp_word_in.last_res  = (count_ff == CNT_W'(1));
               rsp_word_in.overflow  = ovf_ff;
               count_in              = count_ff - CNT_W'(1);
               if (count_ff == CNT_W'(1)) begin
                  state_in = ST_LOAD;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ===== rtl/ins_checker.sv =====
// ----------------------------------------------------------------------------
// ins_checker
// Port-level checks for the insertion sorter, bound to the top level.
// ----------------------------------------------------------------------------
module ins_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input ins_pkg::req_word_type req_word,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input ins_pkg::rsp_word_type rsp_word
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed under stall");

   // the closing word of a run stops input until the run is out
   a_last_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_word.last |=> !req_ready)
      else $error("input taken straight after the closing word");

   // the final result of a run appears only once input is open again
   a_final_reopens: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid && rsp_word.last_res) |-> req_ready)
      else $error("final result shown while input still held");

   // reset leaves no result and an open input
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("bad state after reset");

endmodule

bind insertion_sorter ins_checker u_ins_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_word  (rsp_word)
);

// ===== verif/insertion_sorter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertion_sorter_checker
// Watches both channels of the insertion sorter. It keeps its own sorted run
// of accepted input words and queues the words that the run should drain. It
// compares each accepted result word with the oldest queued one, field by
// field, and reports the number of mismatches to the testbench top.
// ----------------------------------------------------------------------------
module insertion_sorter_checker #(
   parameter int unsigned DEPTH = ins_pkg::DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  ins_pkg::req_word_type req_word,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  ins_pkg::rsp_word_type rsp_word,
   output int                    fail_count,
   output int                    sorted_pending
);

   // predicted run: ascending entries below run_fill
   logic signed [ins_pkg::VALUE_W-1:0] run_store [DEPTH];
   int unsigned                        run_fill;
   logic                               run_dropped;
   ins_pkg::rsp_word_type              sorted_q [$];

   initial begin
      fail_count     = 0;
      sorted_pending = 0;
      run_fill       = 0;
      run_dropped    = 1'b0;
   end

   // insert after every equal entry; a word marked last releases the run
   function automatic void insert_word(input ins_pkg::req_word_type w);
      logic signed [ins_pkg::VALUE_W-1:0] v;
      int unsigned                        pos;
      ins_pkg::rsp_word_type              want;
      v = w.value;
      if (run_fill >= DEPTH) begin
         run_dropped = 1'b1;
      end else begin
         pos = run_fill;
         while (pos > 0 && run_store[pos-1] > v) begin
            run_store[pos] = run_store[pos-1];
            pos--;
         end
         run_store[pos] = v;
         run_fill++;
      end
      if (w.last) begin
         for (int unsigned k = 0; k < run_fill; k++) begin
            want.value_res = run_store[k];
            want.last_res  = (k + 1 == run_fill);
            want.overflow  = run_dropped;
            sorted_q       = {sorted_q, want};
         end
         run_fill    = 0;
         run_dropped = 1'b0;
      end
   endfunction

   function automatic void check_result(input ins_pkg::rsp_word_type got);
      ins_pkg::rsp_word_type want;
      if (sorted_q.size() == 0) begin
         $display("%0t: result word with none expected: value_res %0d last_res %0b overflow %0b",
                  $time, got.value_res, got.last_res, got.overflow);
         fail_count++;
      end else begin
         want = sorted_q.pop_front();
         if (got.value_res !== want.value_res) begin
            $display("%0t: value_res expected %0d, got %0d",
                     $time, want.value_res, got.value_res);
            fail_count++;
         end
         if (got.last_res !== want.last_res) begin
            $display("%0t: last_res expected %0b, got %0b (value_res %0d)",
                     $time, want.last_res, got.last_res, want.value_res);
            fail_count++;
         end
         if (got.overflow !== want.overflow) begin
            $display("%0t: overflow expected %0b, got %0b (value_res %0d)",
                     $time, want.overflow, got.overflow, want.value_res);
            fail_count++;
         end
      end
   endfunction

   // sample both handshakes at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         run_fill    = 0;
         run_dropped = 1'b0;
         sorted_q.delete();
      end else begin
         if (req_valid && req_ready)
            insert_word(req_word);
         if (rsp_valid && rsp_ready)
            check_result(rsp_word);
      end
      sorted_pending = sorted_q.size();
   end

endmodule

// ===== verif/insertion_sorter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insertion_sorter_tb
// Drives runs of signed words into the insertion sorter with random gaps on
// the input side and random stalls on the result side. It starts with a few
// directed runs (field extremes, equal values, a run that overflows the
// store) and follows them with random runs of mixed shape and length. The
// checker beside the block does the prediction; this top gives the verdict.
// ----------------------------------------------------------------------------
module insertion_sorter_tb;

   localparam int unsigned DEPTH        = ins_pkg::DEPTH_DEFAULT;
   localparam int unsigned RANDOM_WORDS = 185;
   localparam int unsigned MAX_GAP      = 14;

   localparam logic signed [ins_pkg::VALUE_W-1:0] VALUE_MAX =
      {1'b0, {(ins_pkg::VALUE_W-1){1'b1}}};
   localparam logic signed [ins_pkg::VALUE_W-1:0] VALUE_MIN =
      {1'b1, {(ins_pkg::VALUE_W-1){1'b0}}};

   // shape of the values within one run
   typedef enum int {
      RUN_RANDOM,
      RUN_DUPLICATES,
      RUN_EXTREMES,
      RUN_RISING,
      RUN_FALLING
   } run_shape_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   ins_pkg::req_word_type req_word;
   logic                  rsp_valid;
   logic                  rsp_ready;
   ins_pkg::rsp_word_type rsp_word;

   int fail_count;
   int sorted_pending;
   int words_sent;
   bit calm_phase;   // no gaps and no stalls while set

   insertion_sorter #(
      .DEPTH(DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   insertion_sorter_checker #(
      .DEPTH(DEPTH)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_word       (req_word),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_word       (rsp_word),
      .fail_count     (fail_count),
      .sorted_pending (sorted_pending)
   );

   always #1 clock = ~clock;

   // Offer one word from a falling edge; returns at the falling edge after
   // the word was taken. Valid stays high straight into the next word when
   // there is no gap.
   task automatic send_word(input logic signed [ins_pkg::VALUE_W-1:0] v,
                            input logic is_last);
      int gap;
      gap = calm_phase ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= '{value: v, last: is_last};
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      words_sent++;
   endtask

   task automatic send_run(input int len, input run_shape_type shape);
      logic signed [ins_pkg::VALUE_W-1:0] base;
      logic signed [ins_pkg::VALUE_W-1:0] v;
      int                                 step;
      base = $urandom;
      step = $urandom_range(1, 1000);
      for (int i = 0; i < len; i++) begin
         case (shape)
            RUN_DUPLICATES: v = $signed($urandom_range(0, 6)) - 3;
            RUN_EXTREMES: begin
               case ($urandom_range(0, 5))
                  0:       v = VALUE_MIN;
                  1:       v = VALUE_MAX;
                  2:       v = VALUE_MIN + 1;
                  3:       v = VALUE_MAX - 1;
                  4:       v = -1;
                  default: v = 0;
               endcase
            end
            RUN_RISING:  v = base + i * step;
            RUN_FALLING: v = base - i * step;
            default:     v = $urandom;
         endcase
         send_word(v, i == len - 1);
      end
   endtask

   // result side: random stall before each word, none in a calm phase
   initial begin : rsp_sink
      int gap;
      @(negedge clock);
      forever begin
         gap = calm_phase ? 0 : $urandom_range(0, MAX_GAP);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // stimulus and verdict
   initial begin : stimulus
      int len;
      int target;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_word   = '0;
      rsp_ready  = 1'b0;
      calm_phase = 1'b0;
      words_sent = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // single word run at the negative extreme
      send_word(VALUE_MIN, 1'b1);
      // field extremes in one run
      send_word(VALUE_MAX, 1'b0);
      send_word(VALUE_MIN, 1'b0);
      send_word(-1, 1'b0);
      send_word(0, 1'b1);
      // equal values around a smaller one
      send_word(7, 1'b0);
      send_word(-7, 1'b0);
      send_word(7, 1'b1);
      // falling values fill the store; the word marked last is dropped
      for (int i = 0; i <= DEPTH; i++)
         send_word(DEPTH - i, i == DEPTH);

      // random runs; some phases run back to back without gaps
      target = words_sent + RANDOM_WORDS;
      while (words_sent < target) begin
         calm_phase = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 9))
            6, 7:    len = DEPTH;
            8:       len = DEPTH + $urandom_range(1, 5);
            9:       len = $urandom_range(1, 3);
            default: len = $urandom_range(1, DEPTH);
         endcase
         send_run(len, run_shape_type'($urandom_range(0, 4)));
      end
      calm_phase = 1'b0;
      req_valid <= 1'b0;

      wait (sorted_pending == 0);
      repeat (DEPTH + 4) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin : watchdog
      #1000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/ins_pkg.sv
rtl/ins_cell.sv
rtl/insertion_sorter.sv
rtl/ins_checker.sv
verif/insertion_sorter_checker.sv
verif/insertion_sorter_tb.sv
